### rtl/core/alu16_pkg.sv
package alu16_pkg;

    localparam int DATA_W     = 16;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = DATA_W / DIV_STAGES;
    localparam int SHAMT_W    = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] HALF_ONES = 16'hFFFF;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_OR  = 4'd4,
        OP_AND = 4'd5,
        OP_XOR = 4'd6,
        OP_SHL = 4'd7,
        OP_SHR = 4'd8,
        OP_NOT = 4'd9,
        OP_CMP = 4'd10
    } op_t;

    // One instruction in flight: finished non-divide result plus divider state
    typedef struct packed {
        logic              is_div;
        logic              div_zero;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] res;
        logic              ovw;
        logic [DATA_W-1:0] ovv;
        logic              eq;
        logic              lt;
    } stage_t;

    typedef struct packed {
        logic              lt;
        logic              eq;
        logic              div_zero;
        logic [DATA_W-1:0] ovv;
        logic              ovw;
        logic [DATA_W-1:0] new_dest;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quot;
    } div_part_t;

    // Restoring division: shift the next dividend bit into the partial
    // remainder, subtract the divisor when it fits, shift in a quotient bit.
    function automatic div_part_t div_steps(input logic [DATA_W-1:0] rem_in,
                                            input logic [DATA_W-1:0] quot_in,
                                            input logic [DATA_W-1:0] divisor);
        div_part_t     r;
        logic [DATA_W:0] trial;
        r.rem  = rem_in;
        r.quot = quot_in;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial  = {r.rem, r.quot[DATA_W-1]};
            r.quot = {r.quot[DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial     = trial - {1'b0, divisor};
                r.quot[0] = 1'b1;
            end
            r.rem = trial[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/alu_16bit_with_overflow_register.sv
// 16-bit ALU with overflow register output, pipelined.
//
// Input stream s_*: one instruction per request (action, destination value,
// source value). Output stream m_*: one result per instruction, in order:
// new destination value, overflow register write and value, and the
// per-instruction flags (divide by zero, equal, less) for the flag register.
//
// Pipeline: a result appears on m_tvalid once its request has passed the
// three inner stages and the output register; the depth is
// set by the 16-bit restoring divider, which retires
// 4 quotient bits on the way into each of those four registers.
// Throughput: one instruction per cycle, every operation, while the receiver does not stall.
//
// Each stage carries its own valid bit and loads whenever it is empty or
// its successor advances, so bubbles collapse and a stalled receiver only
// backs the pipe up: s_tready drops once every stage holds a request.
// Nothing is lost or repeated across a stall.
//
// Reset (aresetn low, synchronous) empties all stages; payload is not reset.
module alu_16bit_with_overflow_register (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] action, [19:4] dest_value, [35:20] source_value, [39:36] zero
    input  logic [alu16_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] new_dest_value, [16] overflow_write, [32:17] overflow_value,
    // [33] div_zero_flag, [34] equal_flag, [35] less_flag, [39:36] zero
    output logic [alu16_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int NST = alu16_pkg::DIV_STAGES - 1;
    localparam int W   = alu16_pkg::DATA_W;

    // Inner stages: the first computes every non-divide result and the
    // first quotient bits, the rest only advance the divider.
    alu16_pkg::stage_t st_reg [NST];
    alu16_pkg::stage_t st_next[NST];
    alu16_pkg::stage_t st0_next;
    logic [NST-1:0]    st_vld_reg;
    logic [NST-1:0]    st_rdy;

    alu16_pkg::result_t out_reg;
    alu16_pkg::result_t out_next;
    logic               out_vld_reg;
    logic               out_rdy;

    logic [3:0]    in_action;
    alu16_pkg::op_t in_op;
    logic [W-1:0]  in_a;
    logic [W-1:0]  in_b;
    logic [2*W-1:0] in_prod;
    alu16_pkg::div_part_t div0;
    alu16_pkg::div_part_t div_mid[NST];
    alu16_pkg::div_part_t div_last;

    assign in_action = s_tdata[3:0];
    assign in_op     = alu16_pkg::op_t'(in_action);
    assign in_a      = s_tdata[19:4];
    assign in_b      = s_tdata[35:20];
    assign in_prod   = in_a * in_b;

    // Ready chain: a stage takes a request when empty or when it hands off.
    always_comb begin
        out_rdy = !out_vld_reg || m_tready;
        st_rdy[NST-1] = !st_vld_reg[NST-1] || out_rdy;
        for (int k = NST - 2; k >= 0; k--) begin
            st_rdy[k] = !st_vld_reg[k] || st_rdy[k+1];
        end
    end

    assign s_tready = st_rdy[0];

    // First stage: decode, every non-divide op, and the first divide bits.
    always_comb begin
        st0_next          = '0;
        st0_next.divisor  = in_b;
        st0_next.res      = in_a;
        st0_next.div_zero = 1'b0;
        st0_next.is_div   = 1'b0;
        case (in_op)
            alu16_pkg::OP_ADD: st0_next.res = in_a + in_b;
            alu16_pkg::OP_SUB: begin
                st0_next.res = in_a - in_b;
                st0_next.ovw = 1'b1;
                st0_next.ovv = (in_a < in_b) ? alu16_pkg::HALF_ONES : '0;
            end
            alu16_pkg::OP_MUL: st0_next.res = in_prod[W-1:0];
            alu16_pkg::OP_DIV: begin
                st0_next.is_div   = 1'b1;
                st0_next.div_zero = (in_b == '0);
            end
            alu16_pkg::OP_OR:  st0_next.res = in_a | in_b;
            alu16_pkg::OP_AND: st0_next.res = in_a & in_b;
            alu16_pkg::OP_XOR: st0_next.res = in_a ^ in_b;
            // amounts of 16 and up clear the low half
            alu16_pkg::OP_SHL: st0_next.res = (in_b[W-1:alu16_pkg::SHAMT_W] == '0) ?
                                   in_a << in_b[alu16_pkg::SHAMT_W-1:0] : '0;
            alu16_pkg::OP_SHR: st0_next.res = (in_b[W-1:alu16_pkg::SHAMT_W] == '0) ?
                                   in_a >> in_b[alu16_pkg::SHAMT_W-1:0] : '0;
            alu16_pkg::OP_NOT: st0_next.res = ~in_a;
            alu16_pkg::OP_CMP: begin
                st0_next.eq = (in_a == in_b);
                st0_next.lt = (in_a < in_b);
            end
            default: st0_next.res = in_a;
        endcase
        div0 = alu16_pkg::div_steps('0, in_a, in_b);
        st0_next.rem  = div0.rem;
        st0_next.quot = div0.quot;
    end

    // Middle stages: advance the divider, carry everything else.
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            div_mid[k] = alu16_pkg::div_steps(st_reg[k].rem, st_reg[k].quot,
                                              st_reg[k].divisor);
        end
        st_next[0] = st0_next;
        for (int k = 1; k < NST; k++) begin
            st_next[k]      = st_reg[k-1];
            st_next[k].rem  = div_mid[k-1].rem;
            st_next[k].quot = div_mid[k-1].quot;
        end
    end

    // Output stage: last divide bits and the divide/non-divide select.
    always_comb begin
        div_last          = div_mid[NST-1];
        out_next.new_dest = st_reg[NST-1].res;
        out_next.ovw      = st_reg[NST-1].ovw;
        out_next.ovv      = st_reg[NST-1].ovv;
        out_next.div_zero = st_reg[NST-1].div_zero;
        out_next.eq       = st_reg[NST-1].eq;
        out_next.lt       = st_reg[NST-1].lt;
        if (st_reg[NST-1].is_div && !st_reg[NST-1].div_zero) begin
            out_next.new_dest = div_last.quot;
            out_next.ovw      = 1'b1;
            out_next.ovv      = div_last.rem;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (st_rdy[0]) begin
                st_vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (st_rdy[k]) begin
                    st_vld_reg[k] <= st_vld_reg[k-1];
                end
            end
            if (out_rdy) begin
                out_vld_reg <= st_vld_reg[NST-1];
            end
        end
    end

    // Payload: advance with the stage, hold otherwise
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (st_rdy[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
        if (out_rdy) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(alu16_pkg::M_TDATA_W - $bits(alu16_pkg::result_t)){1'b0}}, out_reg};

    // A compare never reports both equal and less
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_reg.eq && out_reg.lt))
        else $error("cmp result has both equal and less set");

    // Divide by zero must not write the overflow register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.div_zero) |-> !out_reg.ovw)
        else $error("overflow write on divide by zero");

    // Back-pressure reaches the input only when every stage is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&st_vld_reg) && out_vld_reg && !m_tready)
        else $error("input stalled while the pipeline has room");

endmodule

### tb/sv/alu16_result_checker.sv
`timescale 1ns / 1ps

module alu16_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [3:0] action, [19:4] dest_value, [35:20] source_value, [39:36] zero
    input  logic [alu16_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] new_dest_value, [16] overflow_write, [32:17] overflow_value,
    // [33] div_zero_flag, [34] equal_flag, [35] less_flag, [39:36] zero
    input  logic [alu16_pkg::M_TDATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              pending
);

    alu16_pkg::result_t queued_outcomes[$];

    // Compute the full 32-bit result, keep its low half as the new destination.
    function automatic alu16_pkg::result_t alu_outcome(
            input logic [3:0] act,
            input logic [alu16_pkg::DATA_W-1:0] a,
            input logic [alu16_pkg::DATA_W-1:0] b);
        alu16_pkg::result_t r;
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wide;
        r    = '0;
        wa   = {16'h0000, a};
        wb   = {16'h0000, b};
        wide = wa;
        case (act)
            alu16_pkg::OP_ADD: wide = wa + wb;
            alu16_pkg::OP_SUB: begin
                wide  = wa - wb;
                r.ovw = 1'b1;
                r.ovv = wide[31:16];
            end
            alu16_pkg::OP_MUL: wide = wa * wb;
            alu16_pkg::OP_DIV: begin
                if (b == '0) begin
                    r.div_zero = 1'b1;
                end else begin
                    wide  = wa / wb;
                    r.ovw = 1'b1;
                    r.ovv = 16'(wa % wb);
                end
            end
            alu16_pkg::OP_OR:  wide = wa | wb;
            alu16_pkg::OP_AND: wide = wa & wb;
            alu16_pkg::OP_XOR: wide = wa ^ wb;
            alu16_pkg::OP_SHL: wide = (wb < 32) ? (wa << wb[4:0]) : 32'h0;
            alu16_pkg::OP_SHR: wide = (wb < 32) ? (wa >> wb[4:0]) : 32'h0;
            alu16_pkg::OP_NOT: wide = ~wa;
            alu16_pkg::OP_CMP: begin
                if (a == b) begin
                    r.eq = 1'b1;
                end else if (a < b) begin
                    r.lt = 1'b1;
                end
            end
            default: ;
        endcase
        r.new_dest = wide[alu16_pkg::DATA_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic [alu16_pkg::DATA_W-1:0] want,
                               input logic [alu16_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        alu16_pkg::result_t got;
        alu16_pkg::result_t want;
        if (aresetn) begin
            // Retire before accepting: no request can finish on its own edge.
            if (m_tvalid && m_tready) begin
                got = alu16_pkg::result_t'(m_tdata[$bits(alu16_pkg::result_t)-1:0]);
                if (queued_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = queued_outcomes.pop_front();
                    check_field("new_dest_value", want.new_dest, got.new_dest);
                    check_field("overflow_write", 16'(want.ovw), 16'(got.ovw));
                    check_field("overflow_value", want.ovv, got.ovv);
                    check_field("div_zero_flag", 16'(want.div_zero), 16'(got.div_zero));
                    check_field("equal_flag", 16'(want.eq), 16'(got.eq));
                    check_field("less_flag", 16'(want.lt), 16'(got.lt));
                end
            end
            if (s_tvalid && s_tready) begin
                queued_outcomes.push_back(alu_outcome(s_tdata[3:0], s_tdata[19:4],
                                                      s_tdata[35:20]));
            end
        end
        pending = queued_outcomes.size();
    end

endmodule

### tb/sv/tb_alu_16bit_with_overflow_register.sv
`timescale 1ns / 1ps

module tb_alu_16bit_with_overflow_register;

    localparam int CLK_HALF        = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 1050;
    localparam int HOLD_CYCLES     = 60;
    // The pipe is four stages deep; give a stray extra result time to show.
    localparam int DRAIN_CYCLES    = 12;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // [3:0] action, [19:4] dest_value, [35:20] source_value, [39:36] zero
    logic [alu16_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [15:0] new_dest_value, [16] overflow_write, [32:17] overflow_value,
    // [33] div_zero_flag, [34] equal_flag, [35] less_flag, [39:36] zero
    logic [alu16_pkg::M_TDATA_W-1:0] m_tdata;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;

    // Random idling on both sides; cleared for the quiet stretch.
    bit idle_on = 1'b1;
    // Ask the receiver for one long hold-off; it clears this when done.
    bit hold_go = 1'b0;

    alu_16bit_with_overflow_register dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alu16_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Stop a hung run: a stuck handshake must not spin forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_alu_16bit_with_overflow_register failed");
            $finish;
        end
    end

    // Receiver: drop m_tready at random, with odds of about 31 in a hundred, while idling is on.
    // On request, hold it low for a long stretch so the pipe backs up into
    // s_tready while the sender keeps offering.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_go = 1'b0;
            end
            m_tready <= !idle_on || ($urandom_range(99) >= 31);
        end
    end

    // Offer one request; called on a falling edge, returns on a falling edge
    // after the request was taken. Idle gaps come first, so s_tvalid is only
    // lowered when a gap is really inserted.
    task automatic send_request(input logic [3:0] act,
                                input logic [alu16_pkg::DATA_W-1:0] a,
                                input logic [alu16_pkg::DATA_W-1:0] b);
        while (idle_on && ($urandom_range(99) < 31)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {4'b0000, b, a, act};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Favor the corners: zero, all ones, tiny values and the top bit.
    function automatic logic [alu16_pkg::DATA_W-1:0] pick_operand();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return alu16_pkg::HALF_ONES;
            2:       return 16'($urandom_range(15));
            3:       return 16'h8000 | 16'($urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [3:0]                   act;
        logic [alu16_pkg::DATA_W-1:0] a;
        logic [alu16_pkg::DATA_W-1:0] b;

        // Hold reset low at the start, then release it on a falling edge.
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: carries, borrows, extremes and every operation.
        send_request(alu16_pkg::OP_ADD, alu16_pkg::HALF_ONES, alu16_pkg::HALF_ONES);
        send_request(alu16_pkg::OP_ADD, 16'h0000, 16'h0000);
        send_request(alu16_pkg::OP_SUB, 16'h0000, 16'h0001);
        send_request(alu16_pkg::OP_SUB, 16'h1234, 16'h1234);
        send_request(alu16_pkg::OP_SUB, alu16_pkg::HALF_ONES, 16'h0000);
        send_request(alu16_pkg::OP_MUL, alu16_pkg::HALF_ONES, alu16_pkg::HALF_ONES);
        send_request(alu16_pkg::OP_DIV, alu16_pkg::HALF_ONES, 16'h0001);
        send_request(alu16_pkg::OP_DIV, 16'h0007, 16'h0000);
        send_request(alu16_pkg::OP_DIV, 16'h0000, alu16_pkg::HALF_ONES);
        send_request(alu16_pkg::OP_DIV, 16'd1000, 16'd7);
        send_request(alu16_pkg::OP_OR, 16'hA5A5, 16'h5A5A);
        send_request(alu16_pkg::OP_AND, alu16_pkg::HALF_ONES, 16'h0F0F);
        send_request(alu16_pkg::OP_XOR, alu16_pkg::HALF_ONES, 16'h00FF);
        send_request(alu16_pkg::OP_SHL, 16'h0001, 16'd15);
        send_request(alu16_pkg::OP_SHL, alu16_pkg::HALF_ONES, 16'd16);
        send_request(alu16_pkg::OP_SHL, alu16_pkg::HALF_ONES, 16'd32);
        send_request(alu16_pkg::OP_SHL, alu16_pkg::HALF_ONES, alu16_pkg::HALF_ONES);
        send_request(alu16_pkg::OP_SHR, alu16_pkg::HALF_ONES, 16'd15);
        send_request(alu16_pkg::OP_SHR, alu16_pkg::HALF_ONES, 16'd31);
        send_request(alu16_pkg::OP_SHR, alu16_pkg::HALF_ONES, 16'd32);
        send_request(alu16_pkg::OP_NOT, 16'h0F0F, alu16_pkg::HALF_ONES);
        send_request(alu16_pkg::OP_CMP, 16'h4321, 16'h4321);
        send_request(alu16_pkg::OP_CMP, 16'h0001, alu16_pkg::HALF_ONES);
        send_request(alu16_pkg::OP_CMP, alu16_pkg::HALF_ONES, 16'h0000);
        send_request(4'd11, 16'h1111, 16'h2222);
        send_request(4'd15, alu16_pkg::HALF_ONES, alu16_pkg::HALF_ONES);

        // Random: mostly legal operations, a few unknown codes.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == 250) idle_on = 1'b0;
            if (i == 450) idle_on = 1'b1;
            if (i == 600) hold_go = 1'b1;
            if (i == 800) begin
                // Pause the sender until every result has come back.
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending != 0);
            end
            if ($urandom_range(99) < 92) begin
                act = 4'($urandom_range(alu16_pkg::OP_CMP));
            end else begin
                act = 4'($urandom_range(15, 11));
            end
            a = pick_operand();
            b = pick_operand();
            // Keep most shift amounts in 0..40, spanning the 16 and 32 boundaries.
            if ((act == alu16_pkg::OP_SHL || act == alu16_pkg::OP_SHR) &&
                $urandom_range(3) != 0) begin
                b = 16'($urandom_range(40));
            end
            if (act == alu16_pkg::OP_DIV && $urandom_range(7) == 0) begin
                b = 16'h0000;
            end
            send_request(act, a, b);
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every outstanding result, then watch for strays.
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_alu_16bit_with_overflow_register passed");
        end else begin
            $display("tb_alu_16bit_with_overflow_register failed");
        end
        $finish;
    end

endmodule
